[hw/rtl/sha256_message_hasher_defines.svh]
// assertion macros for the hasher rtl, used by the sequencer
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while arst_n is low
`define SHMH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off while arst_n is low
`define SHMH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SHMH_ASSERT_IMP(lbl, ante, cons, msg)
`define SHMH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/shmh_pkg.sv]
// types, constants and round functions of the sha-256 message hasher
`default_nettype none
package shmh_pkg;

	localparam logic [5:0] FILL_LEN   = 6'd56;
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [7:0] BYTE_MARK  = 8'h80;
	localparam logic [2:0] WORD_LAST  = 3'd7;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUTL
	} state_t;

	typedef enum logic [1:0] {
		RET_IDLE,
		RET_PAD,
		RET_DONE
	} ret_t;

	typedef enum logic [1:0] {
		SEL_IN,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} sel_t;

	typedef struct packed {
		logic       push;
		sel_t       sel;
		logic       add_len;
		logic       load_work;
		logic       round;
		logic [5:0] round_idx;
		logic       fold;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       out_busy;
	} sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = 32'h6a09e667;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_const(input logic [5:0] i);
		logic [31:0] r;
		case (i)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = 32'h428a2f98;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/shmh_datapath.sv]
// byte packing, message schedule, round logic, chaining value and digest buffer
`default_nettype none
module shmh_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     msg_byte,
	input  wire shmh_pkg::cmd_t cmd,
	output shmh_pkg::sts_t      sts,
	output logic                dig_valid,
	input  wire logic           dig_ready,
	output shmh_pkg::out_t      dig_item
);

	logic [31:0] chain_q [8];
	logic [31:0] work_q  [8];
	logic [31:0] sched_q [16];
	logic [23:0] acc_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [31:0] out_q   [8];
	logic [2:0]  out_idx_q;
	logic        out_busy_q;

	logic [7:0]  push_byte;
	logic [31:0] push_word;
	logic [2:0]  len_sel;
	logic [31:0] t1, t2, w_new;
	logic        dig_take;

	// padding source: length bytes go out most significant first
	assign len_sel = shmh_pkg::WORD_LAST - fill_q[2:0];

	always_comb begin
		case (cmd.sel)
			shmh_pkg::SEL_IN:   push_byte = msg_byte;
			shmh_pkg::SEL_MARK: push_byte = shmh_pkg::BYTE_MARK;
			shmh_pkg::SEL_ZERO: push_byte = 8'h00;
			shmh_pkg::SEL_LEN:  push_byte = len_q[{len_sel, 3'b000} +: 8];
			default:            push_byte = 8'h00;
		endcase
	end

	assign push_word = {acc_q, push_byte};

	always_comb begin
		t1 = work_q[7] + shmh_pkg::bsig1(work_q[4])
			+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ shmh_pkg::round_const(cmd.round_idx) + sched_q[0];
		t2 = shmh_pkg::bsig0(work_q[0])
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
		w_new = sched_q[0] + shmh_pkg::ssig0(sched_q[1]) + sched_q[9]
			+ shmh_pkg::ssig1(sched_q[14]);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q <= push_word[23:0];
		end
		if (cmd.round || (cmd.push && (fill_q[1:0] == 2'b11))) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= cmd.round ? w_new : push_word;
		end
		if (cmd.load_work) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
		if (cmd.load_out) begin
			for (int i = 0; i < 8; i++) begin
				out_q[i] <= chain_q[i];
			end
		end else if (dig_take) begin
			for (int i = 0; i < 7; i++) begin
				out_q[i] <= out_q[i + 1];
			end
		end
	end

	assign dig_take = out_busy_q && dig_ready;

	// state with defined reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= shmh_pkg::init_hash(3'(i));
			end
			fill_q     <= '0;
			len_q      <= '0;
			out_idx_q  <= '0;
			out_busy_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.load_out) begin
				len_q <= '0;
			end else if (cmd.add_len) begin
				len_q <= len_q + 64'd8;
			end
			if (cmd.load_out) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= shmh_pkg::init_hash(3'(i));
				end
			end else if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
			if (cmd.load_out) begin
				out_busy_q <= 1'b1;
				out_idx_q  <= '0;
			end else if (dig_take) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (out_idx_q == shmh_pkg::WORD_LAST) begin
					out_busy_q <= 1'b0;
				end
			end
		end
	end

	assign sts.fill     = fill_q;
	assign sts.out_busy = out_busy_q;

	assign dig_valid            = out_busy_q;
	assign dig_item.digest_word = out_q[0];
	assign dig_item.word_index  = out_idx_q;
	assign dig_item.last_word   = (out_idx_q == shmh_pkg::WORD_LAST);

endmodule
`default_nettype wire

[hw/rtl/shmh_ctrl.sv]
// sequencer for byte intake, padding, round count and digest hand-off
`default_nettype none
`include "sha256_message_hasher_defines.svh"
module shmh_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           msg_valid,
	output logic                msg_ready,
	input  wire logic           byte_present,
	input  wire logic           end_of_message,
	input  wire shmh_pkg::sts_t sts_i,
	output shmh_pkg::cmd_t      cmd_o
);

	shmh_pkg::state_t state_q, state_d;
	shmh_pkg::ret_t   ret_q, ret_d;
	logic [5:0]       round_q;
	logic             mark_q;
	logic             lenph_q;
	logic             take;
	logic             full;
	shmh_pkg::sel_t   pad_sel;

	assign msg_ready = (state_q == shmh_pkg::ST_IDLE);
	assign take      = msg_valid && msg_ready;
	assign full      = (sts_i.fill == shmh_pkg::FILL_LAST);

	// padding byte: mark first, then zeros up to the length field, then the length bytes
	always_comb begin
		if (!mark_q) begin
			pad_sel = shmh_pkg::SEL_MARK;
		end else if (lenph_q || (sts_i.fill == shmh_pkg::FILL_LEN)) begin
			pad_sel = shmh_pkg::SEL_LEN;
		end else begin
			pad_sel = shmh_pkg::SEL_ZERO;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			shmh_pkg::ST_IDLE: begin
				if (take) begin
					if (byte_present && full) begin
						state_d = shmh_pkg::ST_ROUND;
						ret_d   = end_of_message ? shmh_pkg::RET_PAD : shmh_pkg::RET_IDLE;
					end else if (end_of_message) begin
						state_d = shmh_pkg::ST_PAD;
					end
				end
			end
			shmh_pkg::ST_PAD: begin
				if (full) begin
					state_d = shmh_pkg::ST_ROUND;
					ret_d   = (pad_sel == shmh_pkg::SEL_LEN) ? shmh_pkg::RET_DONE
						: shmh_pkg::RET_PAD;
				end
			end
			shmh_pkg::ST_ROUND: begin
				if (round_q == shmh_pkg::ROUND_LAST) begin
					state_d = shmh_pkg::ST_FOLD;
				end
			end
			shmh_pkg::ST_FOLD: begin
				case (ret_q)
					shmh_pkg::RET_IDLE: state_d = shmh_pkg::ST_IDLE;
					shmh_pkg::RET_PAD:  state_d = shmh_pkg::ST_PAD;
					shmh_pkg::RET_DONE: state_d = shmh_pkg::ST_OUTL;
					default:            state_d = shmh_pkg::ST_IDLE;
				endcase
			end
			shmh_pkg::ST_OUTL: begin
				if (!sts_i.out_busy) begin
					state_d = shmh_pkg::ST_IDLE;
				end
			end
			default: state_d = shmh_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd_o           = '0;
		cmd_o.sel       = shmh_pkg::SEL_IN;
		cmd_o.round_idx = round_q;
		case (state_q)
			shmh_pkg::ST_IDLE: begin
				cmd_o.push      = take && byte_present;
				cmd_o.add_len   = take && byte_present;
				cmd_o.load_work = take && byte_present && full;
			end
			shmh_pkg::ST_PAD: begin
				cmd_o.push      = 1'b1;
				cmd_o.sel       = pad_sel;
				cmd_o.load_work = full;
			end
			shmh_pkg::ST_ROUND: begin
				cmd_o.round = 1'b1;
			end
			shmh_pkg::ST_FOLD: begin
				cmd_o.fold = 1'b1;
			end
			shmh_pkg::ST_OUTL: begin
				cmd_o.load_out = !sts_i.out_busy;
			end
			default: begin
				cmd_o.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shmh_pkg::ST_IDLE;
			ret_q   <= shmh_pkg::RET_IDLE;
			round_q <= '0;
			mark_q  <= 1'b0;
			lenph_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (cmd_o.round) begin
				round_q <= round_q + 6'd1;
			end
			if (cmd_o.load_out) begin
				mark_q  <= 1'b0;
				lenph_q <= 1'b0;
			end else if (state_q == shmh_pkg::ST_PAD) begin
				mark_q <= 1'b1;
				if (pad_sel == shmh_pkg::SEL_LEN) begin
					lenph_q <= 1'b1;
				end
			end
		end
	end

	`SHMH_ASSERT_IMP(a_load_out_free, cmd_o.load_out, !sts_i.out_busy, "digest loaded over undelivered words")
	`SHMH_ASSERT_NEXT(a_rounds_to_fold, (state_q == shmh_pkg::ST_ROUND) && (round_q == shmh_pkg::ROUND_LAST), state_q == shmh_pkg::ST_FOLD, "compression did not end after the last round")
	`SHMH_ASSERT_IMP(a_len_tail, (state_q == shmh_pkg::ST_PAD) && lenph_q, sts_i.fill[5:3] == 3'b111, "length field outside the block tail")
	`SHMH_ASSERT_IMP(a_block_full, cmd_o.load_work, cmd_o.push && full, "compression started on a partial block")

endmodule
`default_nettype wire

[hw/rtl/sha256_message_hasher.sv]
// top level of the sha-256 message hasher
// usage:
//  msg channel (msg_valid/msg_ready/msg_item) takes one word per item: a message
//  byte with byte_present set, end_of_message on the closing item; a closing item
//  with byte_present low closes the message without adding a byte
//  dig channel (dig_valid/dig_ready/dig_item) gives the eight digest words,
//  word_index 0 (most significant) first, last_word set on word 7
//  throughput: one byte per cycle into the block buffer while the sequencer is idle;
//  each full 64-byte block then holds the input while its 64 rounds run on the one
//  round unit and the result is folded into the chaining value
//  after the closing item the padding bytes (64 - fill, or that plus 64 if the
//  length field spills into a second block) are pushed, each padded block is
//  compressed, and then the digest is loaded into the output buffer
//  the digest sits in its own output buffer, so the next message streams in while
//  words are still waiting; a second digest waits only if the buffer is still full
//  reset: chaining value to the standard initial words, length and fill cleared,
//  no digest pending; loading each digest resets chaining value and length the same way
//  a stalled receiver holds the current word steady until taken
`default_nettype none
module sha256_message_hasher (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           msg_valid,
	output logic                msg_ready,
	input  wire shmh_pkg::in_t  msg_item,
	output logic                dig_valid,
	input  wire logic           dig_ready,
	output shmh_pkg::out_t      dig_item
);

	shmh_pkg::cmd_t cmd;
	shmh_pkg::sts_t sts;

	// sequencer: intake, padding, round count, digest hand-off
	shmh_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_ready      (msg_ready),
		.byte_present   (msg_item.byte_present),
		.end_of_message (msg_item.end_of_message),
		.sts_i          (sts),
		.cmd_o          (cmd)
	);

	// schedule, round unit, chaining value and digest buffer
	shmh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_byte  (msg_item.msg_byte),
		.cmd       (cmd),
		.sts       (sts),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig_item  (dig_item)
	);

endmodule
`default_nettype wire

[bench/sha256_digest_checker.sv]
// scoreboard for the sha-256 message hasher: digest prediction and word comparison
`timescale 1ns / 1ps
module sha256_digest_checker
	import shmh_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic msg_valid,
	input  wire logic msg_ready,
	input  wire in_t  msg_item,
	input  wire logic dig_valid,
	input  wire logic dig_ready,
	input  wire out_t dig_item,
	output int        fail_count,
	output int        words_pending,
	output int        digests_done
);

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int         LEN_POS  = 56;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic [31:0] chain [8];
	logic [7:0]  block_bytes [64];
	int          fill_bytes;
	logic [63:0] msg_bits;
	out_t        expected_digest_words [$];

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		logic [63:0] both;
		both = {x, x} >> n;
		return both[31:0];
	endfunction

	task automatic compress_block();
		logic [31:0] sched [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
				block_bytes[4*i+2], block_bytes[4*i+3]};
		for (i = 16; i < 64; i++)
			sched[i] = sched[i-16] + sched[i-7]
				+ (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
				+ (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10));
		{a, b, c, d} = {chain[0], chain[1], chain[2], chain[3]};
		{e, f, g, h} = {chain[4], chain[5], chain[6], chain[7]};
		for (i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
				+ ((e & f) ^ (~e & g)) + ROUND_K[i] + sched[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
				+ ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic absorb_byte(input logic [7:0] value);
		block_bytes[fill_bytes] = value;
		fill_bytes++;
		if (fill_bytes == 64) begin
			compress_block();
			fill_bytes = 0;
		end
	endtask

	task automatic restart_message();
		int i;
		for (i = 0; i < 8; i++)
			chain[i] = SHA_IV[i];
		fill_bytes = 0;
		msg_bits = '0;
	endtask

	// pad, append the length, and queue the eight digest words
	task automatic close_message();
		logic [63:0] len;
		out_t        w;
		int          i;
		len = msg_bits;
		absorb_byte(PAD_MARK);
		while (fill_bytes != LEN_POS)
			absorb_byte(8'h00);
		for (i = 0; i < 8; i++)
			block_bytes[LEN_POS + i] = len[63 - 8*i -: 8];
		compress_block();
		for (i = 0; i < 8; i++) begin
			w.digest_word = chain[i];
			w.word_index  = i[2:0];
			w.last_word   = (i == 7);
			expected_digest_words.push_back(w);
		end
		restart_message();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: digest mismatch on %s: got %h, expected %h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic check_word(input out_t got);
		out_t want;
		if (expected_digest_words.size() == 0) begin
			report_mismatch("unexpected word", got.digest_word, '0);
		end else begin
			want = expected_digest_words.pop_front();
			if (got.digest_word !== want.digest_word)
				report_mismatch("digest_word", got.digest_word, want.digest_word);
			if (got.word_index !== want.word_index)
				report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
			if (got.last_word !== want.last_word)
				report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
			if (want.last_word)
				digests_done++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			restart_message();
			expected_digest_words.delete();
			fail_count    = 0;
			digests_done  = 0;
			words_pending = 0;
		end else begin
			if (dig_valid && dig_ready)
				check_word(dig_item);
			if (msg_valid && msg_ready) begin
				if (msg_item.byte_present) begin
					absorb_byte(msg_item.msg_byte);
					msg_bits += 64'd8;
				end
				if (msg_item.end_of_message)
					close_message();
			end
			words_pending = expected_digest_words.size();
		end
	end

endmodule

[bench/sha256_message_hasher_tb.sv]
// testbench top: message stimulus, digest receiver and verdict for the hasher
`timescale 1ns / 1ps
module sha256_message_hasher_tb;
	import shmh_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RANDOM_WORDS = 370;
	localparam int MIN_DIGESTS  = 8;
	localparam int LONG_HOLD    = 600;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_ready;
	in_t  msg_item  = '0;
	logic dig_valid;
	logic dig_ready = 1'b0;
	out_t dig_item;

	int fail_count;
	int words_pending;
	int digests_done;
	int cycle_count  = 0;
	int random_words = 0;  // message words of the random part, empty fillers excluded
	bit calm      = 1'b0;  // no idling on either side while set
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	sha256_message_hasher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg_item  (msg_item),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig_item  (dig_item)
	);

	sha256_digest_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_valid     (msg_valid),
		.msg_ready     (msg_ready),
		.msg_item      (msg_item),
		.dig_valid     (dig_valid),
		.dig_ready     (dig_ready),
		.dig_item      (dig_item),
		.fail_count    (fail_count),
		.words_pending (words_pending),
		.digests_done  (digests_done)
	);

	// idle length: mostly none or short, now and then a long one
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic in_t make_word(input logic [7:0] value, input logic present,
			input logic last);
		in_t w;
		w.msg_byte       = value;
		w.byte_present   = present;
		w.end_of_message = last;
		return w;
	endfunction

	// offer one word at the falling edge and hold it until the hasher takes it
	task automatic send_word(input in_t w);
		@(negedge clk);
		msg_valid <= 1'b1;
		msg_item  <= w;
		do
			@(posedge clk);
		while (!msg_ready);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			@(negedge clk);
			msg_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// random bytes, now and then an ignored empty word in between; the close is
	// either on the last byte or on a separate empty closing word
	task automatic send_message(input int n_bytes, input bit close_empty);
		int i;
		for (i = 0; i < n_bytes; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b0));
			send_word(make_word(8'($urandom_range(0, 255)), 1'b1,
				!close_empty && (i == n_bytes - 1)));
			random_words++;
			idle_for(gap_cycles());
		end
		if (close_empty) begin
			send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
			random_words++;
			idle_for(gap_cycles());
		end
	endtask

	// sender pauses until every digest word so far has come back
	task automatic drain_digests();
		idle_for(1);
		wait (words_pending == 0);
	endtask

	// receiver: runs of ready and stalls, with one long hold-off on request
	initial begin : digest_receiver
		int run_len;
		int hold_cycles;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				@(negedge clk);
				dig_ready <= 1'b0;
				for (hold_cycles = 1; hold_cycles < LONG_HOLD; hold_cycles++)
					@(negedge clk);
				hold_done = 1'b1;
			end
			run_len = $urandom_range(1, 7);
			@(negedge clk);
			dig_ready <= 1'b1;
			repeat (run_len - 1) @(negedge clk);
			run_len = gap_cycles();
			if (run_len > 0) begin
				@(negedge clk);
				dig_ready <= 1'b0;
				repeat (run_len - 1) @(negedge clk);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d digest words outstanding",
			cycle_count, words_pending);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int msg_count;
		int n_bytes;
		int r;
		bit close_empty;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, back to back: empty message, single-byte extremes,
		// an empty closing word after bytes, ignored empty words mid-message
		calm = 1'b1;
		send_word(make_word(8'h00, 1'b0, 1'b1));
		send_word(make_word(8'h00, 1'b1, 1'b1));
		send_word(make_word(8'hff, 1'b1, 1'b1));
		send_word(make_word(8'hff, 1'b0, 1'b0));
		send_word(make_word(8'h61, 1'b1, 1'b0));
		send_word(make_word(8'h62, 1'b1, 1'b0));
		send_word(make_word(8'h5a, 1'b0, 1'b0));
		send_word(make_word(8'h63, 1'b1, 1'b0));
		send_word(make_word(8'hff, 1'b0, 1'b1));
		send_word(make_word(8'haa, 1'b1, 1'b0));
		send_word(make_word(8'h55, 1'b1, 1'b1));
		send_word(make_word(8'h00, 1'b1, 1'b0));
		send_word(make_word(8'hff, 1'b1, 1'b0));
		send_word(make_word(8'h00, 1'b0, 1'b1));
		calm = 1'b0;
		drain_digests();

		// random part: first the padding boundaries (length field fits, length
		// field spills into a second block, exactly one full block), then mostly
		// short messages with a few long ones
		msg_count = 0;
		while (random_words < RANDOM_WORDS || digests_done < MIN_DIGESTS) begin
			calm = (msg_count % 6 == 4);
			r = $urandom_range(0, 99);
			case (msg_count)
				0: n_bytes = 55;
				1: n_bytes = 56;
				2: n_bytes = 64;
				default: begin
					if (msg_count >= 5 && msg_count <= 9)
						n_bytes = $urandom_range(0, 6);
					else if (r < 10)
						n_bytes = $urandom_range(55, 65);
					else if (r < 18)
						n_bytes = $urandom_range(0, 130);
					else
						n_bytes = $urandom_range(0, 12);
				end
			endcase
			close_empty = (n_bytes == 0) || ($urandom_range(0, 4) == 0);
			// receiver stops for a long while; the next few short messages pile
			// up behind the digest buffer until the input stalls
			if (msg_count == 5)
				hold_req = 1'b1;
			send_message(n_bytes, close_empty);
			if (msg_count % 7 == 3)
				drain_digests();
			msg_count++;
		end

		drain_digests();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d random messages (%0d words) after the directed cases, %0d digests",
			msg_count, random_words, digests_done);
		$display("padding boundaries, empty closes and a %0d-cycle receiver hold-off (%s)",
			LONG_HOLD, hold_done ? "done" : "not reached");
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sha256_message_hasher.f]
+incdir+hw/rtl
hw/rtl/shmh_pkg.sv
hw/rtl/shmh_datapath.sv
hw/rtl/shmh_ctrl.sv
hw/rtl/sha256_message_hasher.sv
bench/sha256_digest_checker.sv
bench/sha256_message_hasher_tb.sv
